// ===== design/fucbp_pkg.sv =====
// Package for the fixed-width / unary code bit packer.
// Holds widths, sequencer step and branch codes, and the microcode table.
// No dependencies.
package fucbp_pkg;

  localparam int CODE_W        = 16;
  localparam int CFG_W         = 5;
  localparam int BYTE_W        = 8;
  localparam int FILL_W        = 3;
  localparam int REM_W         = 9;
  localparam int TAKE_W        = 4;
  localparam int MAX_CODE_BITS = 16;
  localparam int MAX_UNARY     = 255;
  localparam logic [CFG_W-1:0] CODE_WIDTH_RST = 5'd8;

  localparam int STEP_W = 2;
  localparam logic [STEP_W-1:0] STEP_FETCH = 2'd0;
  localparam logic [STEP_W-1:0] STEP_CHUNK = 2'd1;
  localparam logic [STEP_W-1:0] STEP_FLUSH = 2'd2;
  localparam logic [STEP_W-1:0] STEP_SPARE = 2'd3;

  localparam int SEQ_W = 2;
  localparam logic [SEQ_W-1:0] SEQ_DISPATCH = 2'd0;
  localparam logic [SEQ_W-1:0] SEQ_UNTIL    = 2'd1;
  localparam logic [SEQ_W-1:0] SEQ_GOTO     = 2'd2;

  typedef struct packed {
    logic              in_rdy;
    logic              chunk_en;
    logic              flush_en;
    logic [SEQ_W-1:0]  seq;
    logic [STEP_W-1:0] target;
    logic [STEP_W-1:0] alt_target;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '{in_rdy: 1'b0, chunk_en: 1'b0, flush_en: 1'b0, seq: SEQ_GOTO,
          target: STEP_FETCH, alt_target: STEP_FETCH};
    case (step)
      STEP_FETCH: begin
        c.in_rdy     = 1'b1;
        c.seq        = SEQ_DISPATCH;
        c.target     = STEP_CHUNK;
        c.alt_target = STEP_FLUSH;
      end
      STEP_CHUNK: begin
        c.chunk_en = 1'b1;
        c.seq      = SEQ_UNTIL;
        c.target   = STEP_FETCH;
      end
      STEP_FLUSH: begin
        c.flush_en = 1'b1;
        c.seq      = SEQ_GOTO;
        c.target   = STEP_FETCH;
      end
      default: begin
        c.seq    = SEQ_GOTO;
        c.target = STEP_FETCH;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== design/fucbp_if.sv =====
// Channel interfaces for the bit packer: input codes, packed bytes, width config.
// Depends on fucbp_pkg for field widths.
interface fucbp_in_if import fucbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_value;
  logic              finish;
  modport source (output valid, code_value, finish, input ready);
  modport sink (input valid, code_value, finish, output ready);
endinterface

interface fucbp_out_if import fucbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;
  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink (input valid, out_byte, last_of_run, output ready);
endinterface

interface fucbp_cfg_if import fucbp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] code_width;
  modport source (output valid, code_width, input ready);
  modport sink (input valid, code_width, output ready);
endinterface

// ===== design/fixed_or_unary_code_bit_packer_top.sv =====
// Top level of the MSB-first bit packer for fixed-width or unary codes.
// Depends on fucbp_pkg and the channel interfaces in fucbp_if.sv.
//
//   channel   dir  payload                    request taken when
//   in_req    in   code_value[15:0], finish   valid & ready
//   out_req   out  out_byte[7:0], last_of_run valid & ready
//   cfg_req   in   code_width[4:0]            valid & ready (ready always high)
//
// The fetch step takes a request, then each chunk step moves up to the bits left
// in the current byte until the code is spent; a finish goes to the flush step.
// A full output register stalls the step that would emit into it.
// Reset (rst_n low, synchronous) clears the packer and sets code_width to 8.
module fixed_or_unary_code_bit_packer_top import fucbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  fucbp_in_if.sink    in_req,
  fucbp_out_if.source out_req,
  fucbp_cfg_if.sink   cfg_req
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CFG_W-1:0]  width_r;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              unary_r, unary_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [BYTE_W-1:0] pend_r, pend_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [BYTE_W-1:0] obyte_r, obyte_nxt;
  logic              olast_r, olast_nxt;

  ctrl_t             ctrl;
  logic              accept;
  logic              out_busy;
  logic              stall;
  logic              emit;
  logic [TAKE_W-1:0] room;
  logic [TAKE_W-1:0] take;
  logic [TAKE_W-1:0] shamt;
  logic [REM_W-1:0]  left;
  logic [BYTE_W-1:0] mask;
  logic [CODE_W-1:0] shifted;
  logic [BYTE_W-1:0] chunk;
  logic [BYTE_W-1:0] pend_new;
  logic [TAKE_W-1:0] fill_new;
  logic              full;
  logic [REM_W-1:0]  width_rem;
  logic [REM_W-1:0]  unary_rem;

  assign ctrl     = ucode(step_r);
  assign accept   = in_req.valid && ctrl.in_rdy;
  assign out_busy = ovalid_r && !out_req.ready;

  assign in_req.ready        = ctrl.in_rdy;
  assign cfg_req.ready       = 1'b1;
  assign out_req.valid       = ovalid_r;
  assign out_req.out_byte    = obyte_r;
  assign out_req.last_of_run = olast_r;

  assign width_rem = (width_r > CFG_W'(MAX_CODE_BITS)) ? REM_W'(MAX_CODE_BITS)
                                                       : REM_W'(width_r);
  assign unary_rem = (in_req.code_value > CODE_W'(MAX_UNARY))
                     ? REM_W'(MAX_UNARY + 1)
                     : REM_W'(in_req.code_value[BYTE_W-1:0]) + REM_W'(1);

  always_comb begin
    room     = TAKE_W'(BYTE_W) - TAKE_W'(fill_r);
    take     = (rem_r < REM_W'(room)) ? rem_r[TAKE_W-1:0] : room;
    left     = rem_r - REM_W'(take);
    shamt    = room - take;
    mask     = BYTE_W'((9'd1 << take) - 9'd1);
    shifted  = code_r >> left[TAKE_W-1:0];
    if (unary_r) begin
      chunk = mask & ~{{(BYTE_W-1){1'b0}}, (left == '0)};
    end else begin
      chunk = shifted[BYTE_W-1:0] & mask;
    end
    pend_new = pend_r | (chunk << shamt[FILL_W-1:0]);
    fill_new = TAKE_W'(fill_r) + take;
    full     = (fill_new == TAKE_W'(BYTE_W));
  end

  always_comb begin
    step_nxt   = step_r;
    code_nxt   = code_r;
    unary_nxt  = unary_r;
    rem_nxt    = rem_r;
    pend_nxt   = pend_r;
    fill_nxt   = fill_r;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    emit       = 1'b0;
    stall      = 1'b0;

    if (accept && !in_req.finish) begin
      code_nxt  = in_req.code_value;
      unary_nxt = (width_r == '0);
      rem_nxt   = (width_r == '0) ? unary_rem : width_rem;
    end

    if (ctrl.chunk_en) begin
      stall = full && out_busy;
      if (!stall) begin
        rem_nxt = left;
        if (full) begin
          emit      = 1'b1;
          obyte_nxt = pend_new;
          olast_nxt = (left < REM_W'(BYTE_W));
          pend_nxt  = '0;
          fill_nxt  = '0;
        end else begin
          pend_nxt = pend_new;
          fill_nxt = fill_new[FILL_W-1:0];
        end
      end
    end

    if (ctrl.flush_en) begin
      stall = (fill_r != '0) && out_busy;
      if (!stall) begin
        if (fill_r != '0) begin
          emit      = 1'b1;
          obyte_nxt = pend_r;
          olast_nxt = 1'b1;
        end
        pend_nxt = '0;
        fill_nxt = '0;
      end
    end

    case (ctrl.seq)
      SEQ_DISPATCH: begin
        if (accept) begin
          step_nxt = in_req.finish ? ctrl.alt_target : ctrl.target;
        end
      end
      SEQ_UNTIL: begin
        if (!stall && left == '0) begin
          step_nxt = ctrl.target;
        end
      end
      SEQ_GOTO: begin
        if (!stall) begin
          step_nxt = ctrl.target;
        end
      end
      default: step_nxt = STEP_FETCH;
    endcase

    ovalid_nxt = out_busy || emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_FETCH;
      width_r  <= CODE_WIDTH_RST;
      rem_r    <= '0;
      pend_r   <= '0;
      fill_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      step_r   <= step_nxt;
      rem_r    <= rem_nxt;
      pend_r   <= pend_nxt;
      fill_r   <= fill_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_req.valid) begin
        width_r <= cfg_req.code_width;
      end
    end
  end

  always_ff @(posedge clk) begin
    code_r  <= code_nxt;
    unary_r <= unary_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> rem_r == '0)
    else $error("request taken while code bits remain");

  a_chunk_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == STEP_CHUNK |-> rem_r != '0)
    else $error("chunk step with no bits left");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == STEP_FLUSH && !stall) |=> (fill_r == '0 && pend_r == '0))
    else $error("packer not cleared after finish");

  a_emit_space: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !out_busy)
    else $error("byte emitted into occupied output register");

endmodule
